// ----- rtl/wsac_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsac_pkg
// Shared types, widths, register codes and reset values for the weight
// settle auto-capture block.
// ----------------------------------------------------------------------------
package wsac_pkg;

    // Field widths.
    localparam int RAW_W    = 19;
    localparam int WEIGHT_W = 20;
    localparam int THR_W    = 18;
    localparam int SETTLE_W = 16;
    localparam int NOW_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    // Default width of the internal millisecond timebase.
    localparam int TIME_BITS_DEF = 32;

    // Configuration register reset values.
    localparam logic signed [RAW_W-1:0] OFFSET_RST   = '0;
    localparam logic [THR_W-1:0]        PRESENCE_RST = THR_W'(1);
    localparam logic [THR_W-1:0]        EMPTY_RST    = THR_W'(50);
    localparam logic [THR_W-1:0]        TOL_RST      = THR_W'(20);
    localparam logic [SETTLE_W-1:0]     SETTLE_RST   = SETTLE_W'(600);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET   = 3'd0,
        CFG_PRESENCE = 3'd1,
        CFG_EMPTY    = 3'd2,
        CFG_TOL      = 3'd3,
        CFG_SETTLE   = 3'd4
    } t_cfg_idx;

    // Request codes.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_SAVE   = 1'b1;

    // Capture flow states.
    typedef enum logic [1:0] {
        FLOW_LOAD   = 2'd0,
        FLOW_STABLE = 2'd1,
        FLOW_REMOVE = 2'd2
    } t_flow;

    // Configuration register set.
    typedef struct packed {
        logic signed [RAW_W-1:0] offset;
        logic [THR_W-1:0]        presence;
        logic [THR_W-1:0]        empty;
        logic [THR_W-1:0]        tol;
        logic [SETTLE_W-1:0]     settle;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic signed [WEIGHT_W-1:0] shown;
        logic                       changed;
        logic                       added;
        logic signed [WEIGHT_W-1:0] added_w;
        t_flow                      flow;
    } t_result;

endpackage

// ----- rtl/wsac_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsac_step
// Combinational step for one item: offset correction, capture flow next
// state and the result item.
// ----------------------------------------------------------------------------
module wsac_step
    import wsac_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  t_cfg                       i_cfg,
    input  logic                       i_req_type,
    input  logic signed [RAW_W-1:0]    i_raw_weight,
    input  logic [TIME_BITS-1:0]       i_now,
    input  t_flow                      i_flow,
    input  logic signed [WEIGHT_W-1:0] i_ref,
    input  logic [TIME_BITS-1:0]       i_start,
    input  logic signed [WEIGHT_W-1:0] i_prev,
    output t_flow                      o_flow,
    output logic signed [WEIGHT_W-1:0] o_ref,
    output logic [TIME_BITS-1:0]       o_start,
    output logic signed [WEIGHT_W-1:0] o_prev,
    output t_result                    o_result
);

    logic signed [WEIGHT_W-1:0]   w_raw;
    logic signed [WEIGHT_W-1:0]   w_sum;
    logic signed [WEIGHT_W-1:0]   w_corr;
    logic signed [WEIGHT_W-1:0]   w_empty;
    logic                         w_apply;
    logic                         w_below;
    logic                         w_save_ok;
    logic signed [WEIGHT_W:0]     w_diff;
    logic [WEIGHT_W:0]            w_absd;
    logic                         w_moved;
    logic [TIME_BITS-1:0]         w_elapsed;
    logic [TIME_BITS+SETTLE_W-1:0] w_settle_ext;
    logic                         w_settled;

    // Offset correction, clamped at zero.
    assign w_raw   = WEIGHT_W'(i_raw_weight);
    assign w_apply = (w_raw > $signed({2'b00, i_cfg.presence})) && (i_cfg.offset != '0);
    assign w_sum   = w_raw + WEIGHT_W'(i_cfg.offset);
    assign w_corr  = !w_apply ? w_raw : (w_sum < 0 ? '0 : w_sum);

    // Threshold and stability compares.
    assign w_empty   = $signed({2'b00, i_cfg.empty});
    assign w_below   = w_corr < w_empty;
    assign w_save_ok = i_prev >= w_empty;
    assign w_diff    = (WEIGHT_W+1)'(w_corr) - (WEIGHT_W+1)'(i_ref);
    assign w_absd    = w_diff[WEIGHT_W] ? (WEIGHT_W+1)'(-w_diff) : w_diff;
    assign w_moved   = w_absd >= (WEIGHT_W+1)'(i_cfg.tol);

    // Elapsed time wraps with the timebase width.
    assign w_elapsed    = i_now - i_start;
    assign w_settle_ext = {{TIME_BITS{1'b0}}, i_cfg.settle};
    assign w_settled    = w_elapsed > w_settle_ext[TIME_BITS-1:0];

    // Next state.
    always_comb begin
        o_flow  = i_flow;
        o_ref   = i_ref;
        o_start = i_start;
        o_prev  = i_prev;
        if (i_req_type == REQ_SAVE) begin
            if (w_save_ok) begin
                o_flow  = FLOW_REMOVE;
                o_ref   = i_prev;
                o_start = i_now;
            end
        end else begin
            o_prev = w_corr;
            if (w_below) begin
                if (i_flow != FLOW_LOAD) begin
                    o_flow  = FLOW_LOAD;
                    o_ref   = '0;
                    o_start = '0;
                end
            end else begin
                unique case (i_flow)
                    FLOW_LOAD: begin
                        o_flow  = FLOW_STABLE;
                        o_ref   = w_corr;
                        o_start = i_now;
                    end
                    FLOW_STABLE: begin
                        if (w_moved) begin
                            o_ref   = w_corr;
                            o_start = i_now;
                        end else if (w_settled) begin
                            o_flow = FLOW_REMOVE;
                        end
                    end
                    FLOW_REMOVE: begin
                        o_flow = FLOW_REMOVE;
                    end
                    default: begin
                        o_flow = i_flow;
                    end
                endcase
            end
        end
    end

    // Result item.
    always_comb begin
        o_result.shown   = w_corr;
        o_result.changed = 1'b0;
        o_result.added   = 1'b0;
        o_result.added_w = '0;
        o_result.flow    = o_flow;
        if (i_req_type == REQ_SAVE) begin
            o_result.shown = i_prev;
            if (w_save_ok) begin
                o_result.added   = 1'b1;
                o_result.added_w = i_prev;
            end
        end else begin
            o_result.changed = w_corr != i_prev;
            if (!w_below && i_flow == FLOW_STABLE && !w_moved && w_settled) begin
                o_result.added   = 1'b1;
                o_result.added_w = w_corr;
            end
        end
    end

endmodule

// ----- rtl/weight_settle_auto_capture.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weight_settle_auto_capture
// Scale weight correction with an automatic capture of settled loads.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (i_req_type, i_raw_weight, i_now_ms) enter on i_in_valid and
//   are taken at a clock edge where i_in_valid is high and o_in_stall is low.
//   Each item gives exactly one result item on o_out_valid, taken when
//   i_out_stall is low.
//   Each item passes through the input register, then the correction and
//   flow update run in one pass and load the result register. Throughput
//   is one item per cycle unless the receiver stalls; the flow state is
//   read and written in the same cycle that the result register loads.
//   When the receiver stalls, the result register holds, then the input
//   register fills, and o_in_stall rises; no item is lost or repeated.
//   Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at
//   the next edge and belong to idle periods; unknown indexes are ignored.
//   Synchronous reset empties both registers, returns the flow to waiting
//   for a load, clears the reference and previous weights and the window
//   start, and loads the register defaults.
// ----------------------------------------------------------------------------
module weight_settle_auto_capture
    import wsac_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_req_type,
    input  logic signed [RAW_W-1:0]    i_raw_weight,
    input  logic [NOW_W-1:0]           i_now_ms,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [WEIGHT_W-1:0] o_shown_weight,
    output logic                       o_weight_changed,
    output logic                       o_item_added,
    output logic signed [WEIGHT_W-1:0] o_added_weight,
    output logic [1:0]                 o_flow_state
);

    t_cfg                       r_cfg;
    logic                       r_in_valid;
    logic                       r_in_req;
    logic signed [RAW_W-1:0]    r_in_raw;
    logic [TIME_BITS-1:0]       r_in_now;
    logic                       r_out_valid;
    t_result                    r_out;
    t_flow                      r_flow;
    logic signed [WEIGHT_W-1:0] r_ref;
    logic [TIME_BITS-1:0]       r_start;
    logic signed [WEIGHT_W-1:0] r_prev;

    t_flow                      n_flow;
    logic signed [WEIGHT_W-1:0] n_ref;
    logic [TIME_BITS-1:0]       n_start;
    logic signed [WEIGHT_W-1:0] n_prev;
    t_result                    n_out;

    logic                       w_out_load;
    logic                       w_in_load;
    logic [TIME_BITS+NOW_W-1:0] w_now_ext;

    // Pipeline advance.
    assign w_out_load = r_in_valid && (!r_out_valid || !i_out_stall);
    assign w_in_load  = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !w_out_load;

    // Timestamp sized to the timebase.
    assign w_now_ext = {{TIME_BITS{1'b0}}, i_now_ms};

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset   <= OFFSET_RST;
            r_cfg.presence <= PRESENCE_RST;
            r_cfg.empty    <= EMPTY_RST;
            r_cfg.tol      <= TOL_RST;
            r_cfg.settle   <= SETTLE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_OFFSET:   r_cfg.offset   <= $signed(i_cfg_data);
                CFG_PRESENCE: r_cfg.presence <= i_cfg_data[THR_W-1:0];
                CFG_EMPTY:    r_cfg.empty    <= i_cfg_data[THR_W-1:0];
                CFG_TOL:      r_cfg.tol      <= i_cfg_data[THR_W-1:0];
                CFG_SETTLE:   r_cfg.settle   <= i_cfg_data[SETTLE_W-1:0];
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_load) begin
            r_in_valid <= 1'b1;
        end else if (w_out_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_load) begin
            r_in_req <= i_req_type;
            r_in_raw <= i_raw_weight;
            r_in_now <= w_now_ext[TIME_BITS-1:0];
        end
    end

    // Correction and capture flow for the item in the input register.
    wsac_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .i_cfg        (r_cfg),
        .i_req_type   (r_in_req),
        .i_raw_weight (r_in_raw),
        .i_now        (r_in_now),
        .i_flow       (r_flow),
        .i_ref        (r_ref),
        .i_start      (r_start),
        .i_prev       (r_prev),
        .o_flow       (n_flow),
        .o_ref        (n_ref),
        .o_start      (n_start),
        .o_prev       (n_prev),
        .o_result     (n_out)
    );

    // Flow state, updated as each item moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow  <= FLOW_LOAD;
            r_ref   <= '0;
            r_start <= '0;
            r_prev  <= '0;
        end else if (w_out_load) begin
            r_flow  <= n_flow;
            r_ref   <= n_ref;
            r_start <= n_start;
            r_prev  <= n_prev;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_shown_weight   = r_out.shown;
    assign o_weight_changed = r_out.changed;
    assign o_item_added     = r_out.added;
    assign o_added_weight   = r_out.added_w;
    assign o_flow_state     = r_out.flow;

endmodule

// ----- sim/weight_settle_auto_capture_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weight_settle_auto_capture_test
// Self-checking bench for the weight settle auto-capture block. A behavioral
// model of the weight correction and the load/stable/removal flow predicts
// every result item. Directed items hit thresholds, clamping, settle-time
// edges and timestamp wrap. Random placements follow under several register
// settings, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module weight_settle_auto_capture_test;
    import wsac_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int MAX_GRAMS   = 200000;

    // Clock, reset and block inputs, all known from time zero.
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       i_req_type = REQ_SAMPLE;
    logic signed [RAW_W-1:0]    i_raw_weight = '0;
    logic [NOW_W-1:0]           i_now_ms = '0;
    logic                       i_out_stall = 1'b0;

    logic                       o_in_stall;
    logic                       o_out_valid;
    logic signed [WEIGHT_W-1:0] o_shown_weight;
    logic                       o_weight_changed;
    logic                       o_item_added;
    logic signed [WEIGHT_W-1:0] o_added_weight;
    logic [1:0]                 o_flow_state;

    // Model copy of the registers, at their reset values.
    logic signed [RAW_W-1:0]    cfg_offset = OFFSET_RST;
    logic [THR_W-1:0]           cfg_presence = PRESENCE_RST;
    logic [THR_W-1:0]           cfg_empty = EMPTY_RST;
    logic [THR_W-1:0]           cfg_tol = TOL_RST;
    logic [SETTLE_W-1:0]        cfg_settle = SETTLE_RST;

    // Model copy of the flow state.
    t_flow                      flow = FLOW_LOAD;
    logic signed [WEIGHT_W-1:0] anchor_weight = '0;
    logic [NOW_W-1:0]           window_start = '0;
    logic signed [WEIGHT_W-1:0] prev_weight = '0;

    t_result                    pending_readouts[$];
    logic [NOW_W-1:0]           clock_ms = '0;
    bit                         idle_on = 1'b1;
    int                         stall_left = 0;
    int                         quiet_cycles = 0;
    int                         error_count = 0;
    int                         items_accepted = 0;
    int                         results_checked = 0;
    int                         captures_seen = 0;
    int                         settings_loaded = 0;

    weight_settle_auto_capture dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_raw_weight     (i_raw_weight),
        .i_now_ms         (i_now_ms),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_shown_weight   (o_shown_weight),
        .o_weight_changed (o_weight_changed),
        .o_item_added     (o_item_added),
        .o_added_weight   (o_added_weight),
        .o_flow_state     (o_flow_state)
    );

    always #5 i_clk = ~i_clk;

    // Prints one mismatch line (the first 40 only) and counts it.
    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= 40) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
    endtask

    // Applies one item to the model state and returns the result it gives.
    function automatic t_result scale_step(input logic req,
                                           input logic signed [RAW_W-1:0] raw,
                                           input logic [NOW_W-1:0] stamp);
        t_result          r;
        int               w;
        int               d;
        int               empty_g;
        logic [NOW_W-1:0] elapsed;
        r = '0;
        empty_g = int'(cfg_empty);
        if (req == REQ_SAVE) begin
            // A save captures the last shown weight unless the scale is empty.
            w = prev_weight;
            if (w >= empty_g) begin
                r.added = 1'b1;
                r.added_w = WEIGHT_W'(w);
                flow = FLOW_REMOVE;
                anchor_weight = prev_weight;
                window_start = stamp;
            end
        end else begin
            w = raw;
            if (w > int'(cfg_presence) && cfg_offset != 0) begin
                w = w + cfg_offset;
                if (w < 0) begin
                    w = 0;
                end
            end
            if (w != prev_weight) begin
                prev_weight = WEIGHT_W'(w);
                r.changed = 1'b1;
            end
            if (w < empty_g) begin
                if (flow != FLOW_LOAD) begin
                    flow = FLOW_LOAD;
                    anchor_weight = '0;
                    window_start = '0;
                end
            end else if (flow == FLOW_LOAD) begin
                flow = FLOW_STABLE;
                anchor_weight = WEIGHT_W'(w);
                window_start = stamp;
            end else if (flow == FLOW_STABLE) begin
                d = w - anchor_weight;
                if (d < 0) begin
                    d = -d;
                end
                if (d >= int'(cfg_tol)) begin
                    anchor_weight = WEIGHT_W'(w);
                    window_start = stamp;
                end else begin
                    // Elapsed time wraps with the timestamp.
                    elapsed = stamp - window_start;
                    if (elapsed > NOW_W'(cfg_settle)) begin
                        r.added = 1'b1;
                        r.added_w = WEIGHT_W'(w);
                        flow = FLOW_REMOVE;
                    end
                end
            end
        end
        r.shown = WEIGHT_W'(w);
        r.flow = flow;
        return r;
    endfunction

    // Checks each result against the oldest prediction, then predicts for
    // any item taken at this edge.
    always @(posedge i_clk) begin : readout_monitor
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
                if (pending_readouts.size() == 0) begin
                    report_error("result item with no input item waiting");
                end else begin
                    want = pending_readouts.pop_front();
                    results_checked++;
                    if (o_item_added === 1'b1) begin
                        captures_seen++;
                    end
                    if (o_shown_weight !== want.shown) begin
                        report_error($sformatf("shown weight %0d, expected %0d",
                                               o_shown_weight, want.shown));
                    end
                    if (o_weight_changed !== want.changed) begin
                        report_error($sformatf("weight changed %b, expected %b",
                                               o_weight_changed, want.changed));
                    end
                    if (o_item_added !== want.added) begin
                        report_error($sformatf("item added %b, expected %b",
                                               o_item_added, want.added));
                    end
                    if (o_added_weight !== want.added_w) begin
                        report_error($sformatf("added weight %0d, expected %0d",
                                               o_added_weight, want.added_w));
                    end
                    if (o_flow_state !== want.flow) begin
                        report_error($sformatf("flow state %0d, expected %0d",
                                               o_flow_state, want.flow));
                    end
                end
            end
            if (i_in_valid && o_in_stall === 1'b0) begin
                pending_readouts.push_back(scale_step(i_req_type, i_raw_weight, i_now_ms));
                items_accepted++;
            end
        end
    end

    // Receiver stalls in random bursts.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 3);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Ends the run when no item moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles", QUIET_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // Offers one item, with an optional idle burst first, and returns at the
    // edge that takes it. Valid stays high for a following item.
    task automatic send_item(input logic req, input int raw, input logic [NOW_W-1:0] stamp);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_raw_weight <= RAW_W'(raw);
        i_now_ms <= stamp;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    // Stops offering items and waits until every result has come back.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_readouts.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    // Drives one register write; the caller lowers the write enable.
    task automatic write_register(input t_cfg_idx idx, input int value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
        case (idx)
            CFG_OFFSET:   cfg_offset = RAW_W'(value);
            CFG_PRESENCE: cfg_presence = THR_W'(value);
            CFG_EMPTY:    cfg_empty = THR_W'(value);
            CFG_TOL:      cfg_tol = THR_W'(value);
            CFG_SETTLE:   cfg_settle = SETTLE_W'(value);
            default:      ;
        endcase
    endtask

    // Writes all five registers once the block has gone idle.
    task automatic load_settings(input int offset, input int presence, input int empty_g,
                                 input int tol, input int settle);
        wait_for_results();
        write_register(CFG_OFFSET, offset);
        write_register(CFG_PRESENCE, presence);
        write_register(CFG_EMPTY, empty_g);
        write_register(CFG_TOL, tol);
        write_register(CFG_SETTLE, settle);
        i_cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    task automatic load_random_settings();
        int offset;
        case ($urandom_range(0, 2))
            0: offset = 0;
            1: offset = int'($urandom_range(0, 6000)) - 3000;
            default: offset = int'($urandom_range(0, 2 * MAX_GRAMS)) - MAX_GRAMS;
        endcase
        load_settings(offset, $urandom_range(0, 3000), $urandom_range(0, 1000),
                      $urandom_range(1, 500), $urandom_range(0, 3000));
    endtask

    function automatic int clamp_grams(input int v);
        if (v > MAX_GRAMS) begin
            return MAX_GRAMS;
        end
        if (v < -MAX_GRAMS) begin
            return -MAX_GRAMS;
        end
        return v;
    endfunction

    // Advances the timestamp: mostly short steps, sometimes past the settle
    // time, now and then a jump to a random value or to just before wrap.
    function automatic logic [NOW_W-1:0] next_stamp();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            clock_ms = $urandom;
        end else if (pick == 1) begin
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * int'(cfg_settle) + 2);
        end else if (pick < 8) begin
            clock_ms = clock_ms + NOW_W'(cfg_settle) + $urandom_range(0, 40);
        end else begin
            clock_ms = clock_ms + $urandom_range(0, int'(cfg_settle) / 3 + 1);
        end
        return clock_ms;
    endfunction

    // Random traffic: mostly placements that settle and lift off, plus
    // stray save requests and raw noise over the full weight range.
    task automatic run_random_traffic(input int n_items);
        int sent;
        int pick;
        int base;
        int raw;
        int steps;
        int tol_g;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                tol_g = int'(cfg_tol);
                if ($urandom_range(0, 1)) begin
                    base = int'(cfg_empty) + int'($urandom_range(0, 3000));
                end else begin
                    base = $urandom_range(0, MAX_GRAMS);
                end
                base = clamp_grams(base);
                steps = $urandom_range(2, 7);
                for (int k = 0; k < steps; k++) begin
                    raw = base + int'($urandom_range(0, tol_g)) - tol_g / 2;
                    send_item(REQ_SAMPLE, clamp_grams(raw), next_stamp());
                    sent++;
                end
                if ($urandom_range(0, 3) == 0) begin
                    send_item(REQ_SAVE, int'($urandom_range(0, 2 * MAX_GRAMS)) - MAX_GRAMS,
                              next_stamp());
                    sent++;
                end
                // Lift the load off.
                if ($urandom_range(0, 1)) begin
                    raw = -int'($urandom_range(1, MAX_GRAMS));
                end else begin
                    raw = int'($urandom_range(0, int'(cfg_empty))) - 1;
                end
                send_item(REQ_SAMPLE, raw, next_stamp());
                sent++;
            end else begin
                send_item(pick < 17 ? REQ_SAVE : REQ_SAMPLE,
                          int'($urandom_range(0, 2 * MAX_GRAMS)) - MAX_GRAMS, next_stamp());
                sent++;
            end
        end
    endtask

    // Reset values: save while empty, settle-time boundary, capture,
    // window started at timestamp zero, timestamp wrap, tolerance boundary.
    task automatic test_reset_defaults();
        send_item(REQ_SAVE, 0, 32'd500);
        send_item(REQ_SAMPLE, 1000, 32'd1000);
        send_item(REQ_SAMPLE, 1019, 32'd1300);
        send_item(REQ_SAMPLE, 1005, 32'd1600);
        send_item(REQ_SAMPLE, 1005, 32'd1601);
        send_item(REQ_SAMPLE, 49, 32'd1800);
        send_item(REQ_SAMPLE, 50, 32'd0);
        send_item(REQ_SAMPLE, 60, 32'd601);
        send_item(REQ_SAMPLE, -MAX_GRAMS, 32'd700);
        send_item(REQ_SAMPLE, MAX_GRAMS, 32'hFFFF_FF00);
        send_item(REQ_SAMPLE, MAX_GRAMS - 19, 32'h0000_0200);
        send_item(REQ_SAVE, -5, 32'h0000_0300);
        send_item(REQ_SAMPLE, 20, 32'd5000);
        send_item(REQ_SAMPLE, 100, 32'd5100);
        send_item(REQ_SAMPLE, 120, 32'd5800);
        send_item(REQ_SAMPLE, 120, 32'd6401);
    endtask

    // Offset extremes: clamping at zero, the presence boundary, and the
    // largest shown weight captured by a save.
    task automatic test_offset_and_presence();
        load_settings(-MAX_GRAMS, 0, 50, 20, 600);
        send_item(REQ_SAMPLE, 0, 32'd10000);
        send_item(REQ_SAMPLE, 1, 32'd10001);
        send_item(REQ_SAMPLE, MAX_GRAMS, 32'd10002);
        load_settings(MAX_GRAMS, MAX_GRAMS - 1, 50, 20, 600);
        send_item(REQ_SAMPLE, MAX_GRAMS - 1, 32'd11000);
        send_item(REQ_SAMPLE, MAX_GRAMS, 32'd11001);
        send_item(REQ_SAVE, 0, 32'd11002);
    endtask

    // Zero thresholds, then thresholds at MAX_GRAMS and the largest settle time.
    task automatic test_threshold_extremes();
        load_settings(0, 0, 0, 0, 0);
        send_item(REQ_SAMPLE, -1, 32'd20000);
        send_item(REQ_SAMPLE, 0, 32'd20001);
        send_item(REQ_SAMPLE, 0, 32'd20002);
        send_item(REQ_SAVE, 0, 32'd20003);
        load_settings(-1, MAX_GRAMS, MAX_GRAMS, MAX_GRAMS, 65535);
        send_item(REQ_SAMPLE, MAX_GRAMS - 1, 32'd30000);
        send_item(REQ_SAMPLE, MAX_GRAMS, 32'd30001);
        send_item(REQ_SAMPLE, MAX_GRAMS, 32'd95536);
        send_item(REQ_SAMPLE, MAX_GRAMS, 32'd95537);
    endtask

    // Random placements under default, random and extreme settings.
    task automatic test_random_settings();
        clock_ms = $urandom;
        load_settings(0, 1, 50, 20, 600);
        run_random_traffic(100);
        load_random_settings();
        run_random_traffic(100);
        load_random_settings();
        run_random_traffic(100);
        load_settings(-MAX_GRAMS, 0, 0, MAX_GRAMS, 65535);
        run_random_traffic(40);
        load_settings(MAX_GRAMS, MAX_GRAMS, MAX_GRAMS, 1, 0);
        run_random_traffic(40);
    endtask

    // Full rate on both channels, no idling at all.
    task automatic test_back_to_back();
        idle_on = 1'b0;
        load_random_settings();
        run_random_traffic(90);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_offset_and_presence();
        test_threshold_extremes();
        test_random_settings();
        test_back_to_back();
        wait_for_results();
        repeat (4) @(posedge i_clk);
        $display("Run covered %0d items and %0d results, %0d of them captures,",
                 items_accepted, results_checked, captures_seen);
        $display("over %0d register settings; %0d mismatches.",
                 settings_loaded, error_count);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- weight_settle_auto_capture.f -----
rtl/wsac_pkg.sv
rtl/wsac_step.sv
rtl/weight_settle_auto_capture.sv
sim/weight_settle_auto_capture_test.sv
